>>> rtl/core/document_range_locator_top_assert.svh
// ---------------------------------------------------------------------------
// document range locator assertion macros
// shorthand for clocked checks with reset gating
// ---------------------------------------------------------------------------
`ifndef DOCUMENT_RANGE_LOCATOR_TOP_ASSERT_SVH
`define DOCUMENT_RANGE_LOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define DRL_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRL_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/drl_pkg.sv
// ---------------------------------------------------------------------------
// drl_pkg
// shared types and constants of the document range locator
// ---------------------------------------------------------------------------
package drl_pkg;

	localparam int unsigned MAX_DOCS_DEF = 1024;
	localparam int unsigned POS_BITS_DEF = 31;

	localparam int unsigned IDX_W     = 11;
	localparam int unsigned ENTRY_W   = 10;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned APB_W     = 32;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_DOC_COUNT = 1'd0;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_SEEK  = 2'd1,
		OP_FIND  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/core/drl_ram.sv
// ---------------------------------------------------------------------------
// drl_ram
// single-port synchronous ram with registered read
// ---------------------------------------------------------------------------
module drl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> rtl/core/document_range_locator_top.sv
// ---------------------------------------------------------------------------
// document range locator
// range table of documents with binary seek and find over a single-port ram
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  -------------------------------------
//  in       in         in_valid / in_stall   operation, entry_index, entry_start,
//                                            entry_end, query_location
//  out      out        out_valid / out_stall found, doc_index, doc_start, doc_end
//  cfg      in         apb psel/penable      doc_count at byte address 0
//
//  inputs are taken only in idle; a write or unused operation then goes to result
//  a search makes one search step per probe (at most floor(log2(n)) + 1, 11 at 1024)
//  one probe per cycle: one read of the shared start/end ram per cycle
//  reset clears control state only; table contents are undefined until written
//  the result waits in an output register, so a stall there delays only the
//  handoff from the result stage, not work already in progress
// ---------------------------------------------------------------------------
module document_range_locator_top #(
	parameter int unsigned MAX_DOCS = drl_pkg::MAX_DOCS_DEF,
	parameter int unsigned POS_W    = drl_pkg::POS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [drl_pkg::OP_W-1:0]     operation,
	input  logic [drl_pkg::ENTRY_W-1:0]  entry_index,
	input  logic [POS_W-1:0]             entry_start,
	input  logic [POS_W-1:0]             entry_end,
	input  logic [POS_W-1:0]             query_location,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [drl_pkg::IDX_W-1:0]    doc_index,
	output logic [POS_W-1:0]             doc_start,
	output logic [POS_W-1:0]             doc_end,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [drl_pkg::PADDR_W-1:0]  paddr,
	input  logic [drl_pkg::APB_W-1:0]    pwdata,
	output logic [drl_pkg::APB_W-1:0]    prdata,
	output logic                         pready
);

	import drl_pkg::*;

	localparam int unsigned AW = $clog2(MAX_DOCS);
	localparam int unsigned SW = IDX_W + 1;    // signed search bound width
	localparam int unsigned DW = 2 * POS_W;    // ram word: start over end

	// configuration
	logic [IDX_W-1:0]     doc_count_q;
	logic [REG_IDX_W-1:0] reg_sel;
	logic                 cfg_wr;

	// control
	state_t state_q, state_n;
	logic   in_take;
	logic   is_search_in;
	logic   rd_issue;
	logic   res_move;
	logic   go;
	logic   hit;

	// search registers
	logic [OP_W-1:0]        op_q;
	logic [POS_W-1:0]       loc_q;
	logic signed [SW-1:0]   lo_q, hi_q, lo_n, hi_n;
	logic [IDX_W-1:0]       mid_q, mid_n;
	logic [IDX_W+1:0]       mid_sum;
	logic                   cand_found_q, cand_found_n;
	logic [IDX_W-1:0]       cand_idx_q, cand_idx_n;
	logic [POS_W-1:0]       cand_start_q, cand_start_n;
	logic [POS_W-1:0]       cand_end_q, cand_end_n;
	logic [IDX_W-1:0]       n_docs;
	logic signed [SW-1:0]   mid_m1, mid_p1;
	logic                   wr_in_range;

	// table ram
	logic          ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [POS_W-1:0] rd_start, rd_end;

	// result stage and output register
	logic             res_found_q, res_found_n;
	logic [IDX_W-1:0] res_idx_q, res_idx_n;
	logic [POS_W-1:0] res_start_q, res_start_n;
	logic [POS_W-1:0] res_end_q, res_end_n;
	logic             out_valid_q;
	logic             out_found_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [POS_W-1:0] out_start_q, out_end_q;

	// ------------------------------------------------------------------
	// apb register: doc_count at word 0, write completes in access phase
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_count_q <= '0;
		end else if (cfg_wr && reg_sel == REG_DOC_COUNT) begin
			doc_count_q <= pwdata[IDX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_DOC_COUNT) begin
			prdata = APB_W'(doc_count_q);
		end
	end

	// ------------------------------------------------------------------
	// search datapath
	// ------------------------------------------------------------------
	// entries in use, capped at the table depth
	assign n_docs = (32'(doc_count_q) > 32'(MAX_DOCS)) ? IDX_W'(MAX_DOCS) : doc_count_q;
	assign wr_in_range = 32'(entry_index) < 32'(MAX_DOCS);

	assign in_take      = in_valid && !in_stall;
	assign is_search_in = (operation == OP_SEEK) || (operation == OP_FIND);

	assign rd_start = ram_rdata[DW-1:POS_W];
	assign rd_end   = ram_rdata[POS_W-1:0];

	assign mid_m1 = $signed({1'b0, mid_q}) - SW'(1);
	assign mid_p1 = $signed({1'b0, mid_q}) + SW'(1);

	// one probe per cycle: the data for mid_q is in ram_rdata while searching
	always_comb begin
		lo_n         = lo_q;
		hi_n         = hi_q;
		cand_found_n = cand_found_q;
		cand_idx_n   = cand_idx_q;
		cand_start_n = cand_start_q;
		cand_end_n   = cand_end_q;
		hit          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				lo_n         = '0;
				hi_n         = $signed({1'b0, n_docs}) - SW'(1);
				cand_found_n = 1'b0;
			end
			ST_SEARCH: begin
				if (op_q == OP_SEEK) begin
					if (loc_q <= rd_end) begin
						cand_found_n = 1'b1;
						cand_idx_n   = mid_q;
						cand_start_n = rd_start;
						cand_end_n   = rd_end;
						hi_n         = mid_m1;
					end else begin
						lo_n = mid_p1;
					end
				end else begin
					if (loc_q < rd_start) begin
						hi_n = mid_m1;
					end else if (loc_q > rd_end) begin
						lo_n = mid_p1;
					end else begin
						hit = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// next probe: bounds are non-negative whenever the interval is non-empty
	assign go      = (lo_n <= hi_n) && !hit;
	assign mid_sum = (IDX_W + 2)'($unsigned(lo_n)) + (IDX_W + 2)'($unsigned(hi_n));
	assign mid_n   = mid_sum[IDX_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_found_q <= 1'b0;
		end else begin
			cand_found_q <= cand_found_n;
		end
	end

	always_ff @(posedge clk) begin
		lo_q         <= lo_n;
		hi_q         <= hi_n;
		mid_q        <= mid_n;
		cand_idx_q   <= cand_idx_n;
		cand_start_q <= cand_start_n;
		cand_end_q   <= cand_end_n;
		if (in_take) begin
			op_q  <= operation;
			loc_q <= query_location;
		end
	end

	// ------------------------------------------------------------------
	// state machine
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_n = (is_search_in && go) ? ST_SEARCH : ST_RESULT;
				end
			end
			ST_SEARCH: begin
				if (!go) begin
					state_n = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_move) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_issue = 1'b0;
		ram_we   = 1'b0;
		res_move = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				rd_issue = in_valid && is_search_in && go;
				ram_we   = in_valid && (operation == OP_WRITE) && wr_in_range;
			end
			ST_SEARCH: begin
				rd_issue = go;
			end
			ST_RESULT: begin
				res_move = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// table ram: writes land at transfer, reads only while no write can occur
	// ------------------------------------------------------------------
	assign ram_en    = ram_we || rd_issue;
	assign ram_addr  = ram_we ? AW'(entry_index) : AW'(mid_n);
	assign ram_wdata = {entry_start, entry_end};

	drl_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DOCS)
	) u_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// result stage: tracks the item until it reaches the result state
	// ------------------------------------------------------------------
	always_comb begin
		res_found_n = 1'b0;
		res_idx_n   = '0;
		res_start_n = '0;
		res_end_n   = '0;
		if (state_q == ST_IDLE) begin
			case (operation)
				OP_WRITE: begin
					if (wr_in_range) begin
						res_found_n = 1'b1;
						res_idx_n   = IDX_W'(entry_index);
						res_start_n = entry_start;
						res_end_n   = entry_end;
					end
				end
				OP_SEEK:  res_idx_n = doc_count_q;    // empty table miss
				default:  ;
			endcase
		end else begin
			case (op_q)
				OP_SEEK: begin
					if (cand_found_n) begin
						res_found_n = 1'b1;
						res_idx_n   = cand_idx_n;
						res_start_n = cand_start_n;
						res_end_n   = cand_end_n;
					end else begin
						res_idx_n = doc_count_q;
					end
				end
				OP_FIND: begin
					if (hit) begin
						res_found_n = 1'b1;
						res_idx_n   = mid_q;
						res_start_n = rd_start;
						res_end_n   = rd_end;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != ST_RESULT) begin
			res_found_q <= res_found_n;
			res_idx_q   <= res_idx_n;
			res_start_q <= res_start_n;
			res_end_q   <= res_end_n;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_move) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
			out_start_q <= res_start_q;
			out_end_q   <= res_end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign doc_index = out_idx_q;
	assign doc_start = out_start_q;
	assign doc_end   = out_end_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`include "document_range_locator_top_assert.svh"

	`DRL_ASSERT_NOW(a_search_interval, state_q == ST_SEARCH, lo_q <= hi_q, "empty interval probed")
	`DRL_ASSERT_NOW(a_probe_in_bounds, state_q == ST_SEARCH, ($signed({1'b0, mid_q}) >= lo_q) && ($signed({1'b0, mid_q}) <= hi_q), "probe outside interval")
	`DRL_ASSERT_NOW(a_search_op, state_q == ST_SEARCH, (op_q == OP_SEEK) || (op_q == OP_FIND), "search without search op")
	`DRL_ASSERT_NEXT(a_result_held, (state_q == ST_RESULT) && out_valid_q && out_stall, state_q == ST_RESULT, "result dropped under stall")

endmodule

>>> dv/document_range_locator_top_tb.sv
// ---------------------------------------------------------------------------
// document range locator testbench
// drives table writes, seeks and finds through the input channel, keeps its
// own copy of the range table and doc_count, predicts every result and
// compares each output transfer field by field
// ---------------------------------------------------------------------------
module document_range_locator_top_tb;

	import drl_pkg::*;

	localparam int unsigned MAX_DOCS = MAX_DOCS_DEF;
	localparam int unsigned POS_W    = POS_BITS_DEF;

	localparam logic [OP_W-1:0]    OP_UNUSED      = 2'd3;
	localparam logic [POS_W-1:0]   POS_MAX        = {POS_W{1'b1}};
	localparam logic [PADDR_W-1:0] DOC_COUNT_ADDR = PADDR_W'({REG_DOC_COUNT, 2'b00});

	// one input item and one result item
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ENTRY_W-1:0] slot;
		logic [POS_W-1:0]   lo_pos;
		logic [POS_W-1:0]   hi_pos;
		logic [POS_W-1:0]   loc;
	} locator_req_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] doc;
		logic [POS_W-1:0] lo_pos;
		logic [POS_W-1:0] hi_pos;
	} locator_resp_t;

	// -----------------------------------------------------------------------
	// scoreboard: private copy of the range table, binary search predictor
	// and the queue of results still owed by the block
	// -----------------------------------------------------------------------
	class range_scoreboard;
		logic [POS_W-1:0] start_tab [MAX_DOCS];
		logic [POS_W-1:0] end_tab [MAX_DOCS];
		logic [IDX_W-1:0] doc_count;
		locator_resp_t    owed_results [$];
		int               mismatches;

		function new();
			doc_count  = '0;
			mismatches = 0;
		endfunction

		function void set_doc_count(input logic [IDX_W-1:0] value);
			doc_count = value;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// computes the result of one accepted input transfer
		function void note_request(input locator_req_t req);
			locator_resp_t res;
			int            n;
			int            lo;
			int            hi;
			int            mid;
			int            cand;
			bit            done;
			res  = '0;
			n    = (doc_count > MAX_DOCS) ? MAX_DOCS : int'(doc_count);
			lo   = 0;
			hi   = n - 1;
			cand = -1;
			done = 1'b0;
			case (req.op)
				OP_WRITE: begin
					if (int'(req.slot) < MAX_DOCS) begin
						start_tab[req.slot] = req.lo_pos;
						end_tab[req.slot]   = req.hi_pos;
						res = '{1'b1, IDX_W'(req.slot), req.lo_pos, req.hi_pos};
					end
				end
				OP_SEEK: begin
					// earliest document whose end is at or after the location
					while (lo <= hi) begin
						mid = (lo + hi) / 2;
						if (req.loc <= end_tab[mid]) begin
							cand = mid;
							hi   = mid - 1;
						end else begin
							lo = mid + 1;
						end
					end
					if (cand < 0)
						res.doc = doc_count;
					else
						res = '{1'b1, IDX_W'(cand), start_tab[cand], end_tab[cand]};
				end
				OP_FIND: begin
					// document whose range holds the location
					while (!done && lo <= hi) begin
						mid = (lo + hi) / 2;
						if (req.loc < start_tab[mid]) begin
							hi = mid - 1;
						end else if (req.loc > end_tab[mid]) begin
							lo = mid + 1;
						end else begin
							res  = '{1'b1, IDX_W'(mid), start_tab[mid], end_tab[mid]};
							done = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			owed_results.push_back(res);
		endfunction

		task report_mismatch(input string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(input locator_resp_t got);
			locator_resp_t want;
			if (owed_results.size() == 0) begin
				report_mismatch("result transfer with no result owed");
				return;
			end
			want = owed_results.pop_front();
			if (got.hit !== want.hit)
				report_mismatch($sformatf("found %0d, want %0d", got.hit, want.hit));
			if (got.doc !== want.doc)
				report_mismatch($sformatf("doc_index %0d, want %0d", got.doc, want.doc));
			if (got.lo_pos !== want.lo_pos)
				report_mismatch($sformatf("doc_start %0h, want %0h", got.lo_pos, want.lo_pos));
			if (got.hi_pos !== want.hi_pos)
				report_mismatch($sformatf("doc_end %0h, want %0h", got.hi_pos, want.hi_pos));
		endtask
	endclass

	// -----------------------------------------------------------------------
	// block signals, inputs known from time zero
	// -----------------------------------------------------------------------
	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation      = '0;
	logic [ENTRY_W-1:0]  entry_index    = '0;
	logic [POS_W-1:0]    entry_start    = '0;
	logic [POS_W-1:0]    entry_end      = '0;
	logic [POS_W-1:0]    query_location = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic                found;
	logic [IDX_W-1:0]    doc_index;
	logic [POS_W-1:0]    doc_start;
	logic [POS_W-1:0]    doc_end;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [PADDR_W-1:0]  paddr          = '0;
	logic [APB_W-1:0]    pwdata         = '0;
	logic [APB_W-1:0]    prdata;
	logic                pready;

	range_scoreboard sb = new();

	int items_sent = 0;
	int send_calm  = 0;
	int stall_calm = 0;

	document_range_locator_top i_dut (.*);

	always #5 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	// gap length: mostly none or short, a few long, and calm stretches with none
	function automatic int pick_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// -----------------------------------------------------------------------
	// output side: random stall pattern, check every accepted result transfer
	// -----------------------------------------------------------------------
	initial begin
		int len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			len = pick_gap(stall_calm);
			if (len > 0) begin
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// values seen here are the ones from before the edge, so the order of
	// processes in this time step does not matter
	always @(posedge clk) begin
		locator_resp_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{found, doc_index, doc_start, doc_end};
			sb.check_result(seen);
		end
	end

	// -----------------------------------------------------------------------
	// input side
	// -----------------------------------------------------------------------

	// one input transfer, with a random gap in front of it; valid stays high
	// between back-to-back items
	task automatic send_req(input locator_req_t req);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation      <= req.op;
		entry_index    <= req.slot;
		entry_start    <= req.lo_pos;
		entry_end      <= req.hi_pos;
		query_location <= req.loc;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(req);
		items_sent++;
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input int unsigned slot,
		input logic [POS_W-1:0] lo_pos, input logic [POS_W-1:0] hi_pos,
		input logic [POS_W-1:0] loc);
		send_req('{op, ENTRY_W'(slot), lo_pos, hi_pos, loc});
	endtask

	// stop sending and wait until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_doc_count(input logic [IDX_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DOC_COUNT_ADDR;
		pwdata  <= APB_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_doc_count(value);
	endtask

	// fill entries 0..n-1; in order gives non-decreasing ranges that may touch,
	// spread over a random share of the position space
	task automatic load_table(input int n, input bit in_order);
		longint unsigned step;
		longint unsigned cursor;
		logic [POS_W-1:0] lo_pos;
		logic [POS_W-1:0] hi_pos;
		if (n == 0)
			return;
		step = 64'(POS_MAX) / (2 * n + 1);
		if ($urandom_range(0, 3) != 0)
			step = step >> $urandom_range(0, 12);
		cursor = $urandom_range(0, 32'(step));
		for (int i = 0; i < n; i++) begin
			if (in_order) begin
				lo_pos = POS_W'(cursor);
				cursor += $urandom_range(0, 32'(step));
				hi_pos = POS_W'(cursor);
				cursor += $urandom_range(0, 32'(step));
			end else begin
				lo_pos = POS_W'($urandom);
				hi_pos = POS_W'($urandom);
			end
			send_op(OP_WRITE, i, lo_pos, hi_pos, POS_W'($urandom));
		end
	endtask

	// seek or find, mostly aimed at the edges of a document in use
	function automatic locator_req_t make_query(input int n);
		locator_req_t req;
		int           k;
		logic [POS_W-1:0] lo_pos;
		logic [POS_W-1:0] hi_pos;
		req.op     = $urandom_range(0, 1) ? OP_SEEK : OP_FIND;
		req.slot   = ENTRY_W'($urandom);
		req.lo_pos = POS_W'($urandom);
		req.hi_pos = POS_W'($urandom);
		req.loc    = POS_W'($urandom);
		if (n > 0 && $urandom_range(0, 9) < 8) begin
			k      = $urandom_range(0, n - 1);
			lo_pos = sb.start_tab[k];
			hi_pos = sb.end_tab[k];
			case ($urandom_range(0, 4))
				0: req.loc = lo_pos;
				1: req.loc = hi_pos;
				2: req.loc = hi_pos + 1'b1;
				3: req.loc = lo_pos - 1'b1;
				default: begin
					if (hi_pos >= lo_pos)
						req.loc = lo_pos + POS_W'($urandom_range(0, 32'(hi_pos - lo_pos)));
				end
			endcase
		end else if ($urandom_range(0, 3) == 0) begin
			req.loc = $urandom_range(0, 1) ? POS_MAX : '0;
		end
		return req;
	endfunction

	// a batch of lookups with some noise: unused operation, rewrites that
	// may break the order, and writes anywhere in the table
	task automatic run_queries(input int n, input int count);
		int r;
		int k;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_op(OP_UNUSED, $urandom, POS_W'($urandom), POS_W'($urandom),
					POS_W'($urandom));
			end else if (r < 8 && n > 0) begin
				k = $urandom_range(0, n - 1);
				send_op(OP_WRITE, k, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
			end else if (r < 10) begin
				send_op(OP_WRITE, $urandom, POS_W'($urandom), POS_W'($urandom),
					POS_W'($urandom));
			end else begin
				send_req(make_query(n));
			end
		end
	endtask

	// one phase: new doc_count, fresh table of that size, then lookups
	task automatic random_phase();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 8)
			n = 0;
		else if (r < 55)
			n = $urandom_range(1, 8);
		else if (r < 88)
			n = $urandom_range(9, 64);
		else
			n = $urandom_range(65, 300);
		drain();
		write_doc_count(IDX_W'(n));
		load_table(n, $urandom_range(0, 99) < 85);
		run_queries(n, $urandom_range(10, 40));
	endtask

	// -----------------------------------------------------------------------
	// main sequence
	// -----------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset: both searches miss, unused operation
		send_op(OP_SEEK, 0, '0, '0, '0);
		send_op(OP_SEEK, 0, '0, '0, POS_MAX);
		send_op(OP_FIND, 0, '0, '0, POS_MAX);
		send_op(OP_UNUSED, 1023, POS_MAX, POS_MAX, POS_MAX);
		send_op(OP_UNUSED, 0, '0, '0, '0);

		// extreme entries and a small sorted table with a hole between docs
		send_op(OP_WRITE, 1023, POS_MAX, POS_MAX, '0);
		send_op(OP_WRITE, 0, '0, '0, POS_MAX);
		send_op(OP_WRITE, 1, 31'd5, 31'd9, '0);
		drain();
		write_doc_count(IDX_W'(2));
		send_op(OP_SEEK, 0, '0, '0, '0);
		send_op(OP_SEEK, 0, '0, '0, 31'd1);
		send_op(OP_SEEK, 0, '0, '0, 31'd10);
		send_op(OP_FIND, 0, '0, '0, '0);
		send_op(OP_FIND, 0, '0, '0, 31'd3);
		send_op(OP_FIND, 0, '0, '0, 31'd9);
		send_op(OP_FIND, 0, '0, '0, POS_MAX);

		// entry 0 now lies after entry 1: unsorted table
		send_op(OP_WRITE, 0, 31'd100, 31'd200, '0);
		send_op(OP_SEEK, 0, '0, '0, 31'd150);
		send_op(OP_FIND, 0, '0, '0, 31'd150);
		send_op(OP_FIND, 0, '0, '0, 31'd7);

		// the full-table load below already brings the total past a thousand
		while (items_sent < 120)
			random_phase();

		// full table, then doc_count at the limit, above it, and small again
		drain();
		write_doc_count(IDX_W'(MAX_DOCS));
		load_table(MAX_DOCS, 1'b1);
		run_queries(MAX_DOCS, 60);
		send_op(OP_SEEK, 0, '0, '0, POS_MAX);
		drain();
		write_doc_count({IDX_W{1'b1}});
		run_queries(MAX_DOCS, 30);
		send_op(OP_SEEK, 0, '0, '0, POS_MAX);
		send_op(OP_FIND, 0, '0, '0, POS_MAX);
		drain();
		write_doc_count(IDX_W'(MAX_DOCS + 1));
		run_queries(MAX_DOCS, 10);
		drain();
		write_doc_count(IDX_W'(3));
		run_queries(3, 15);

		// let any stray result show up before the verdict
		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
